// File: rtl/oat_pkg.sv
// ----------------------------------------------------------------------------
// oat_pkg
// shared types and codes for the ordered array table
// ----------------------------------------------------------------------------
package oat_pkg;

    // default table depth
    localparam int DEPTH_DEF = 64;

    // field widths
    localparam int KIND_W    = 3;
    localparam int POS_W     = 7;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 7;

    // operation codes
    localparam logic [KIND_W-1:0] K_ADD_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] K_ADD_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] K_INSERT    = 3'd2;
    localparam logic [KIND_W-1:0] K_REM_FRONT = 3'd3;
    localparam logic [KIND_W-1:0] K_REM_BACK  = 3'd4;
    localparam logic [KIND_W-1:0] K_SEARCH    = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // finished result handed from the sequencer to the output register
    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [STATUS_W-1:0]  status;
        logic [ENTRIES_W-1:0] entries;
    } res_t;

endpackage

// File: rtl/oat_ram.sv
// ----------------------------------------------------------------------------
// oat_ram
// generic simple dual-port ram, one write and one registered read a cycle
// ----------------------------------------------------------------------------
module oat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/oat_ctrl.sv
// ----------------------------------------------------------------------------
// oat_ctrl
// sequencer for the table: decodes a word, walks the ram one entry a cycle
// ----------------------------------------------------------------------------
module oat_ctrl #(
    parameter int DEPTH = oat_pkg::DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [oat_pkg::KIND_W-1:0]       in_kind,
    input  logic [oat_pkg::POS_W-1:0]        in_pos,
    input  logic signed [oat_pkg::WORD_W-1:0] in_word,
    output oat_pkg::res_t                    res,
    input  logic                             res_ready,
    output logic [CW-1:0]                    cnt,
    output logic                             ram_we,
    output logic [AW-1:0]                    ram_waddr,
    output logic [oat_pkg::WORD_W-1:0]       ram_wdata,
    output logic [AW-1:0]                    ram_raddr,
    input  logic [oat_pkg::WORD_W-1:0]       ram_rdata
);

    localparam int MW = (CW > oat_pkg::POS_W) ? CW : oat_pkg::POS_W;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP     = 3'd1;
    localparam logic [2:0] S_DOWN   = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_WRITE  = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0]                        state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [AW-1:0]                     idx_reg, idx_next;
    logic [AW-1:0]                     lim_reg, lim_next;
    logic [AW-1:0]                     wr_reg, wr_next;
    logic                              pend_reg, pend_next;
    logic                              last_reg, last_next;
    logic [oat_pkg::WORD_W-1:0]        word_reg, word_next;
    logic                              found_reg, found_next;
    logic [oat_pkg::STATUS_W-1:0]      status_reg, status_next;

    logic                              full;
    logic                              empty;
    logic                              ins_req;
    logic [AW-1:0]                     ins_at;
    logic [oat_pkg::STATUS_W-1:0]      rej_status;
    logic                              at_lim;
    logic                              match;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign at_lim = (idx_reg == lim_reg);
    assign match  = (ram_rdata == word_reg);

    // insert decode: where the new word goes, or why it is refused
    always_comb begin
        ins_req    = 1'b0;
        ins_at     = '0;
        rej_status = oat_pkg::ST_OK;
        case (in_kind)
            oat_pkg::K_ADD_FRONT: begin
                if (full) rej_status = oat_pkg::ST_FULL;
                else ins_req = 1'b1;
            end
            oat_pkg::K_ADD_BACK: begin
                if (full) begin
                    rej_status = oat_pkg::ST_FULL;
                end else begin
                    ins_req = 1'b1;
                    ins_at  = AW'(count_reg);
                end
            end
            oat_pkg::K_INSERT: begin
                if (MW'(in_pos) > MW'(count_reg)) begin
                    rej_status = oat_pkg::ST_RANGE;
                end else if (full) begin
                    rej_status = oat_pkg::ST_FULL;
                end else begin
                    ins_req = 1'b1;
                    ins_at  = AW'(in_pos);
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer next state and ram control
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        lim_next    = lim_reg;
        wr_next     = wr_reg;
        pend_next   = pend_reg;
        last_next   = last_reg;
        word_next   = word_reg;
        found_next  = found_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = wr_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = idx_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    word_next   = in_word;
                    found_next  = 1'b0;
                    status_next = oat_pkg::ST_OK;
                    pend_next   = 1'b0;
                    last_next   = 1'b0;
                    case (in_kind)
                        oat_pkg::K_ADD_FRONT, oat_pkg::K_ADD_BACK, oat_pkg::K_INSERT: begin
                            if (ins_req) begin
                                lim_next = ins_at;
                                if (ins_at == AW'(count_reg)) begin
                                    state_next = S_WRITE;
                                end else begin
                                    idx_next   = AW'(count_reg - CW'(1));
                                    state_next = S_UP;
                                end
                            end else begin
                                status_next = rej_status;
                                state_next  = S_FIN;
                            end
                        end
                        oat_pkg::K_REM_FRONT: begin
                            if (empty) begin
                                status_next = oat_pkg::ST_EMPTY;
                                state_next  = S_FIN;
                            end else if (count_reg == CW'(1)) begin
                                count_next = count_reg - CW'(1);
                                state_next = S_FIN;
                            end else begin
                                idx_next   = AW'(1);
                                lim_next   = AW'(count_reg - CW'(1));
                                state_next = S_DOWN;
                            end
                        end
                        oat_pkg::K_REM_BACK: begin
                            if (empty) status_next = oat_pkg::ST_EMPTY;
                            else count_next = count_reg - CW'(1);
                            state_next = S_FIN;
                        end
                        oat_pkg::K_SEARCH: begin
                            if (empty) begin
                                state_next = S_FIN;
                            end else begin
                                idx_next   = '0;
                                lim_next   = AW'(count_reg - CW'(1));
                                state_next = S_SEARCH;
                            end
                        end
                        default: begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // shift up or down: read one entry, write it one place over next cycle
            S_UP, S_DOWN: begin
                ram_we = pend_reg;
                if (!last_reg) begin
                    pend_next = 1'b1;
                    wr_next   = (state_reg == S_UP) ? idx_reg + AW'(1) : idx_reg - AW'(1);
                    if (at_lim) last_next = 1'b1;
                    else idx_next = (state_reg == S_UP) ? idx_reg - AW'(1) : idx_reg + AW'(1);
                end else begin
                    pend_next = 1'b0;
                    if (state_reg == S_UP) begin
                        state_next = S_WRITE;
                    end else begin
                        count_next = count_reg - CW'(1);
                        state_next = S_FIN;
                    end
                end
            end

            // linear search, stops at the first match
            S_SEARCH: begin
                if (pend_reg && match) begin
                    found_next = 1'b1;
                    state_next = S_FIN;
                end else if (last_reg) begin
                    state_next = S_FIN;
                end else begin
                    pend_next = 1'b1;
                    if (at_lim) last_next = 1'b1;
                    else idx_next = idx_reg + AW'(1);
                end
            end

            // store the new word in the gap
            S_WRITE: begin
                ram_we     = 1'b1;
                ram_waddr  = lim_reg;
                ram_wdata  = word_reg;
                count_next = count_reg + CW'(1);
                state_next = S_FIN;
            end

            // hand the result over once the output register is free
            S_FIN: begin
                if (res_ready) state_next = S_IDLE;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            last_reg  <= last_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        lim_reg    <= lim_next;
        wr_reg     <= wr_next;
        word_reg   <= word_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign cnt         = count_reg;
    assign res.valid   = (state_reg == S_FIN);
    assign res.found   = found_reg;
    assign res.status  = status_reg;
    assign res.entries = oat_pkg::ENTRIES_W'(count_reg);

endmodule

// File: rtl/ordered_array_table_top.sv
// ----------------------------------------------------------------------------
// ordered_array_table_top
// dense ordered table of signed 32-bit words with add, insert, remove, search
// ----------------------------------------------------------------------------
//  channel  dir  fields (lowest bit up)
//  s_       in   tuser: kind[2:0]; tdata: position[6:0], word[38:7], pad[39]
//  m_       out  tdata: found[0], status[2:1], entries[9:3], pad[15:10]
//
//  one word at a time; an insert below the live count, a front removal and a
//  search take longer the more entries they must pass, set by the sequencer
//  walking the ram one entry a cycle
//  reset clears the live count, the sequencer state and the output valid; the ram is not cleared
//  a result waits in the output register; a new word is taken meanwhile, and
//  the next result is held in the sequencer until that register is free
// ----------------------------------------------------------------------------
module ordered_array_table_top #(
    parameter int DEPTH = oat_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // kind
    input  logic [39:0] s_tdata,   // position, word, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // found, status, entries, pad
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    oat_pkg::res_t               res;
    logic                        res_ready;
    logic [CW-1:0]               cnt;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [oat_pkg::WORD_W-1:0]  ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [oat_pkg::WORD_W-1:0]  ram_rdata;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [15:0]                 m_tdata_reg, m_tdata_next;

    // sequencer
    oat_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .in_pos   (s_tdata[6:0]),
        .in_word  (s_tdata[38:7]),
        .res      (res),
        .res_ready(res_ready),
        .cnt      (cnt),
        .ram_we   (ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .ram_raddr(ram_raddr),
        .ram_rdata(ram_rdata)
    );

    // table storage
    oat_ram #(
        .WIDTH(oat_pkg::WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res.valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'b0, res.entries, res.status, res.found};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the live count never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt <= CW'(DEPTH))
        else $error("live count beyond depth");

    // the count moves by at most one per cycle
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (cnt == $past(cnt) || cnt == $past(cnt) + CW'(1) ||
                            cnt + CW'(1) == $past(cnt)))
        else $error("live count jumped");

    // an accepted word keeps the input closed on the next cycle
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while busy");

    // a match is only ever reported with status ok
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[2:1] == oat_pkg::ST_OK))
        else $error("found with a fault status");

endmodule
